[hdl/msot_pkg.sv]
// ----------------------------------------------------------------------------
// msot_pkg: shared types and constants for the one-shot timer bank
// token carried along the slot chain, result limits, seconds to ms conversion
// ----------------------------------------------------------------------------
package msot_pkg;

	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned CNT_W       = 3;
	localparam int unsigned SLOT_W      = 2;
	localparam int unsigned TIME_W      = 32;

	localparam logic [9:0]        MS_PER_SEC  = 10'd1000;
	// largest seconds value whose millisecond count still fits in 32 bits
	localparam logic [TIME_W-1:0] MAX_SECONDS = 32'd4294967;

	localparam logic CMD_ARM  = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	// poll token: walks the chain, one cell per cycle unless paused
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] now;
		logic [CNT_W-1:0]  cnt;
	} tok_t;

	// saturating seconds to milliseconds
	function automatic logic [TIME_W-1:0] sec_to_ms(input logic [TIME_W-1:0] secs);
		logic [TIME_W+9:0] prod;
		begin
			prod = (TIME_W+10)'(secs) * (TIME_W+10)'(MS_PER_SEC);
			if (secs > MAX_SECONDS) begin
				sec_to_ms = '1;
			end else begin
				sec_to_ms = prod[TIME_W-1:0];
			end
		end
	endfunction

endpackage

[hdl/msot_cell.sv]
// ----------------------------------------------------------------------------
// msot_cell: one timer slot
// holds armed flag, start time and delay; checks expiry when the poll token
// sits here and hands the token on to the next cell
// ----------------------------------------------------------------------------
module msot_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [msot_pkg::TIME_W-1:0] wr_start,
	input  logic [msot_pkg::TIME_W-1:0] wr_delay,
	input  logic                        advance,
	input  msot_pkg::tok_t              tok_in,
	output msot_pkg::tok_t              tok_out,
	output logic                        hit
);
	import msot_pkg::*;

	logic              armed_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] delay_q;
	tok_t              tok_q;
	logic [TIME_W-1:0] elapsed;

	// wrap-safe elapsed time
	assign elapsed = tok_q.now - start_q;
	assign hit     = tok_q.valid && armed_q && (elapsed >= delay_q)
	                 && (tok_q.cnt < CNT_W'(MAX_RESULTS));

	always_comb begin
		tok_out.valid = tok_q.valid && advance;
		tok_out.now   = tok_q.now;
		tok_out.cnt   = tok_q.cnt + CNT_W'(hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			if (tok_in.valid) begin
				tok_q <= tok_in;
			end else if (advance) begin
				tok_q.valid <= 1'b0;
			end
			if (wr_en) begin
				armed_q <= 1'b1;
			end else if (hit && advance) begin
				armed_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_q <= wr_start;
			delay_q <= wr_delay;
		end
	end

endmodule

[hdl/multi_slot_oneshot_timer.sv]
// ----------------------------------------------------------------------------
// multi_slot_oneshot_timer: bank of one-shot timer slots
// arm beats load a slot, poll beats report every expired slot in order
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): command, now_ms, slot, delay_seconds
//     arm beat (command = 0): stores now_ms as start and delay_seconds * 1000
//       (saturated to 2^32-1) as delay, marks the slot armed
//     poll beat (command = 1): a token walks the row of slot cells, one cell
//       per cycle while not stalled; each armed cell whose (now_ms - start)
//       mod 2^32 reached its delay disarms and yields a result beat
//   output channel (out_valid/out_ready): fired_slot, last
//     results leave in ascending slot order, last marks the final one
//   input hold and stalls
//     a poll holds the input during the token walk and a flush step that
//     passes on the held result with last set, and longer while the output
//     is stalled; the walk pauses whenever the output register is full and
//     not taken; an arm does not hold the input
//   a result is held back one hit so that last can be set on the final one
//   reset clears all armed flags and the walk; start and delay are stored
//   only on arm
// ----------------------------------------------------------------------------
module multi_slot_oneshot_timer #(
	parameter int unsigned SLOT_COUNT = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [msot_pkg::TIME_W-1:0] now_ms,
	input  logic [msot_pkg::SLOT_W-1:0] slot,
	input  logic [msot_pkg::TIME_W-1:0] delay_seconds,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [msot_pkg::SLOT_W-1:0] fired_slot,
	output logic                        last
);
	import msot_pkg::*;

	localparam int unsigned SEL_W = 8;

	tok_t                  chain [SLOT_COUNT+1];
	logic [SLOT_COUNT-1:0] hit;
	logic [SLOT_COUNT-1:0] tok_busy;
	logic [SLOT_COUNT-1:0] walk_q;
	logic [SLOT_COUNT-1:0] wr_en;
	logic [TIME_W-1:0]     wr_delay;
	logic                  in_fire;
	logic                  advance;
	logic                  step_hit;
	logic [SLOT_W-1:0]     hit_code;

	logic                  flush_q;
	logic                  pend_valid_q;
	logic [SLOT_W-1:0]     pend_slot_q;
	logic                  out_valid_q;
	logic [SLOT_W-1:0]     fired_slot_q;
	logic                  last_q;

	// accept nothing new while a poll walks or flushes
	assign in_ready = !(|tok_busy) && !flush_q;
	assign in_fire  = in_valid && in_ready;
	// the walk steps only when the output register can take a beat
	assign advance  = !out_valid_q || out_ready;
	assign wr_delay = sec_to_ms(delay_seconds);

	// launch the poll token into the first cell
	assign chain[0] = {in_fire && (command == CMD_POLL), now_ms, CNT_W'(0)};

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		assign wr_en[i] = in_fire && (command == CMD_ARM)
		                  && (SEL_W'(slot) == SEL_W'(i));

		msot_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en[i]),
			.wr_start (now_ms),
			.wr_delay (wr_delay),
			.advance  (advance),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1]),
			.hit      (hit[i])
		);
	end

	// only one cell holds the token, so an or of the indices encodes the hit
	always_comb begin
		hit_code = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (hit[i]) begin
				hit_code = hit_code | SLOT_W'(i);
			end
		end
	end
	assign step_hit = |hit;

	// token presence per cell
	assign tok_busy = walk_q;

	// mirror of the token position, shifted in step with the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (chain[i].valid) begin
					walk_q[i] <= 1'b1;
				end else if (advance) begin
					walk_q[i] <= 1'b0;
				end
			end
		end
	end

	// held result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (chain[SLOT_COUNT].valid) begin
				flush_q <= 1'b1;
			end else if (advance) begin
				flush_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b0;
				if (step_hit) begin
					pend_valid_q <= 1'b1;
					out_valid_q  <= pend_valid_q;
				end else if (flush_q) begin
					pend_valid_q <= 1'b0;
					out_valid_q  <= pend_valid_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (step_hit) begin
				pend_slot_q  <= hit_code;
				fired_slot_q <= pend_slot_q;
				last_q       <= 1'b0;
			end else if (flush_q) begin
				fired_slot_q <= pend_slot_q;
				last_q       <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign fired_slot = fired_slot_q;
	assign last       = last_q;

	// checks

	// a single poll token in the row
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(walk_q))
		else $error("more than one poll token in the slot row");

	// the flush cycle never overlaps the walk
	assert property (@(posedge clk) disable iff (!arst_n) !(flush_q && (|walk_q)))
		else $error("flush while token still in the row");

	// a held result exists only inside a poll
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> ((|walk_q) || flush_q))
		else $error("held result outside a poll");

	// a completed flush leaves nothing held
	assert property (@(posedge clk) disable iff (!arst_n)
		(flush_q && advance) |=> !pend_valid_q)
		else $error("held result survived the flush");

endmodule
